[sv/ptw_pkg.sv]
// Shared types and constants for the two-level page table walker.
// Used by the controller, the datapath and the top level; no dependencies.
package ptw_pkg;

    // Physical memory size in bytes (power of two, 4096 to 65536).
    localparam int MEM_BYTES = 32768;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    // Wide enough for base plus index and for any wrapped memory address.
    localparam int WIDE_W    = 17;

    localparam int VADDR_W   = 15;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 5;
    localparam int FRAME_W   = 7;
    localparam int PADDR_W   = FRAME_W + IDX_W;
    localparam int VALID_BIT = 7;

    localparam logic [VADDR_W-1:0] DIR_BASE_RESET = 15'h220;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_XLATE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_WRITE     = 2'd0,
        ST_XLATE     = 2'd1,
        ST_DIR_FAULT = 2'd2,
        ST_TBL_FAULT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TBL,
        S_DATA,
        S_FIN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic ld_in;    // input transfer: latch item, start write or directory read
        logic dir_chk;  // directory entry on read data
        logic tbl_chk;  // table entry on read data
        logic ld_out;   // load output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_write;     // incoming item is a write
        logic entry_valid;  // valid bit of the entry on read data
    } t_dp_stat;

endpackage

[sv/two_level_page_table_walk.sv]
// Top level of the two-level page table walker: stream ports and configuration.
// Depends on ptw_pkg, ptw_ctrl and ptw_dp.
//
//   Port group      Dir  Contents
//   s_axis_*        in   write byte or translate request
//   m_axis_*        out  status, physical address, data and raw entries
//   i_cfg_*         in   directory base register
//
// A write is a memory write and a result step; a translation is three dependent
// reads of the single-port byte memory, each read registered, and a result
// step. A directory fault ends the walk early, skipping the table and data
// reads; a table fault skips the data read. One item is in flight at a time;
// the result register frees the input side while a result waits. Reset sets
// the directory base to 0x220; memory contents are not cleared.
module two_level_page_table_walk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptw_pkg::VADDR_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address [14:0], write_byte [22:15], zero [23]
    input  logic [ptw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // command [0]
    input  logic [ptw_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // physical_address [11:0], read_byte [19:12], directory_entry [27:20],
    // table_entry [35:28], zero [39:36]
    output logic [ptw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status [1:0]
    output logic [ptw_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import ptw_pkg::*;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [1:0]         status;
    logic [PADDR_W-1:0] paddr;
    logic [BYTE_W-1:0]  rbyte;
    logic [BYTE_W-1:0]  dent;
    logic [BYTE_W-1:0]  tent;

    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ptw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_cmd    (s_axis_tuser[0]),
        .i_in_addr   (s_axis_tdata[VADDR_W-1:0]),
        .i_in_wbyte  (s_axis_tdata[VADDR_W +: BYTE_W]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (status),
        .o_paddr     (paddr),
        .o_rbyte     (rbyte),
        .o_dent      (dent),
        .o_tent      (tent)
    );

    assign m_axis_tdata = {4'd0, tent, dent, rbyte, paddr};
    assign m_axis_tuser = status;

endmodule

[sv/ptw_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies; read data holds while the port is not enabled for read.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ptw_ctrl.sv]
// Walk sequencer: input/output handshakes and datapath commands.
// Depends on ptw_pkg.
module ptw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ptw_pkg::t_dp_cmd  o_cmd,
    input  ptw_pkg::t_dp_stat i_stat
);
    import ptw_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_write ? S_FIN : S_TBL;
                end
            end
            S_TBL: begin
                n_state = i_stat.entry_valid ? S_DATA : S_FIN;
            end
            S_DATA: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_in  = i_in_valid;
            end
            S_TBL:  o_cmd.dir_chk = 1'b1;
            S_DATA: o_cmd.tbl_chk = 1'b1;
            S_FIN:  o_cmd.ld_out  = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/ptw_dp.sv]
// Walk datapath: directory base register, memory, entry checks, result register.
// Depends on ptw_pkg and ptw_ram.
module ptw_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ptw_pkg::VADDR_W-1:0]    i_cfg_wdata,
    input  logic                           i_in_cmd,
    input  logic [ptw_pkg::VADDR_W-1:0]    i_in_addr,
    input  logic [ptw_pkg::BYTE_W-1:0]     i_in_wbyte,
    input  ptw_pkg::t_dp_cmd               i_cmd,
    output ptw_pkg::t_dp_stat              o_stat,
    output logic [1:0]                     o_status,
    output logic [ptw_pkg::PADDR_W-1:0]    o_paddr,
    output logic [ptw_pkg::BYTE_W-1:0]     o_rbyte,
    output logic [ptw_pkg::BYTE_W-1:0]     o_dent,
    output logic [ptw_pkg::BYTE_W-1:0]     o_tent
);
    import ptw_pkg::*;

    logic [VADDR_W-1:0] r_dir_base;
    logic [VADDR_W-1:0] r_vaddr;
    t_status            r_status;
    logic [BYTE_W-1:0]  r_dent;
    logic [BYTE_W-1:0]  r_tent;
    logic [PADDR_W-1:0] r_paddr;

    logic [1:0]         r_out_status;
    logic [PADDR_W-1:0] r_out_paddr;
    logic [BYTE_W-1:0]  r_out_rbyte;
    logic [BYTE_W-1:0]  r_out_dent;
    logic [BYTE_W-1:0]  r_out_tent;

    logic               ram_en;
    logic               ram_we;
    logic [MEM_AW-1:0]  ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               in_write;
    logic [IDX_W-1:0]   in_didx;
    logic [WIDE_W-1:0]  dir_sum;
    logic [WIDE_W-1:0]  wr_wide;
    logic [PADDR_W-1:0] tbl_addr;
    logic [PADDR_W-1:0] data_addr;
    logic [WIDE_W-1:0]  tbl_wide;
    logic [WIDE_W-1:0]  data_wide;

    assign in_write  = (i_in_cmd == CMD_WRITE);
    assign in_didx   = i_in_addr[VADDR_W-1 -: IDX_W];
    assign dir_sum   = WIDE_W'(r_dir_base) + WIDE_W'(in_didx);
    assign wr_wide   = WIDE_W'(i_in_addr);
    assign tbl_addr  = {ram_rdata[FRAME_W-1:0], r_vaddr[2*IDX_W-1:IDX_W]};
    assign data_addr = {ram_rdata[FRAME_W-1:0], r_vaddr[IDX_W-1:0]};
    assign tbl_wide  = WIDE_W'(tbl_addr);
    assign data_wide = WIDE_W'(data_addr);

    assign o_stat.in_write    = in_write;
    assign o_stat.entry_valid = ram_rdata[VALID_BIT];

    // Every memory address wraps modulo the memory size.
    always_comb begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = dir_sum[MEM_AW-1:0];
        priority if (i_cmd.ld_in) begin
            ram_en   = 1'b1;
            ram_we   = in_write;
            ram_addr = in_write ? wr_wide[MEM_AW-1:0] : dir_sum[MEM_AW-1:0];
        end else if (i_cmd.dir_chk) begin
            ram_en   = ram_rdata[VALID_BIT];
            ram_addr = tbl_wide[MEM_AW-1:0];
        end else if (i_cmd.tbl_chk) begin
            ram_en   = ram_rdata[VALID_BIT];
            ram_addr = data_wide[MEM_AW-1:0];
        end else begin
            ram_en   = 1'b0;
        end
    end

    ptw_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_wbyte),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_base <= DIR_BASE_RESET;
        end else if (i_cfg_we) begin
            r_dir_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_vaddr  <= i_in_addr;
            r_status <= in_write ? ST_WRITE : ST_XLATE;
            r_dent   <= '0;
            r_tent   <= '0;
            r_paddr  <= '0;
        end
        if (i_cmd.dir_chk) begin
            r_dent <= ram_rdata;
            if (!ram_rdata[VALID_BIT]) begin
                r_status <= ST_DIR_FAULT;
            end
        end
        if (i_cmd.tbl_chk) begin
            r_tent <= ram_rdata;
            if (ram_rdata[VALID_BIT]) begin
                r_paddr <= data_addr;
            end else begin
                r_status <= ST_TBL_FAULT;
            end
        end
    end

    // Read data holds the data byte only on a completed translation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_status <= r_status;
            r_out_paddr  <= r_paddr;
            r_out_rbyte  <= (r_status == ST_XLATE) ? ram_rdata : '0;
            r_out_dent   <= r_dent;
            r_out_tent   <= r_tent;
        end
    end

    assign o_status = r_out_status;
    assign o_paddr  = r_out_paddr;
    assign o_rbyte  = r_out_rbyte;
    assign o_dent   = r_out_dent;
    assign o_tent   = r_out_tent;

endmodule
